### hw/rtl/segment_segment_intersection_macros.svh
// ---------------------------------------------------------------------------
// Segment intersection assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_SEGMENT_INTERSECTION_MACROS_SVH

// assertion with reset disable
`define SGI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion checked during reset as well
`define SGI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sgi_pkg.sv
// ---------------------------------------------------------------------------
// Segment intersection package
// Shared constants for the segment intersection pipeline.
// ---------------------------------------------------------------------------
package sgi_pkg;
  // default coordinate width, signed Q12.4
  localparam int unsigned COORD_WIDTH = 16;
endpackage

### hw/rtl/sgi_front.sv
// ---------------------------------------------------------------------------
// Segment intersection front end
// Direction vectors, cross products, sign fold and hit test (three stages).
// ---------------------------------------------------------------------------
module sgi_front #(
  parameter int unsigned COORD_WIDTH = sgi_pkg::COORD_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [COORD_WIDTH-1:0]        f_sx,
  input  logic signed [COORD_WIDTH-1:0]        f_sy,
  input  logic signed [COORD_WIDTH-1:0]        f_ex,
  input  logic signed [COORD_WIDTH-1:0]        f_ey,
  input  logic signed [COORD_WIDTH-1:0]        s_sx,
  input  logic signed [COORD_WIDTH-1:0]        s_sy,
  input  logic signed [COORD_WIDTH-1:0]        s_ex,
  input  logic signed [COORD_WIDTH-1:0]        s_ey,
  output logic                                 vld3,
  output logic                                 hit3,
  output logic signed [2*COORD_WIDTH+2:0]      d3,
  output logic signed [2*COORD_WIDTH+2:0]      p3,
  output logic signed [COORD_WIDTH:0]          ux3,
  output logic signed [COORD_WIDTH:0]          uy3,
  output logic signed [COORD_WIDTH-1:0]        sx3,
  output logic signed [COORD_WIDTH-1:0]        sy3
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned MW = 2 * DW;
  localparam int unsigned PW = MW + 1;

  // stage 1: differences
  logic                 vld1;
  logic signed [DW-1:0] ux1, uy1, vx1, vy1, wx1, wy1;
  logic signed [CW-1:0] sx1, sy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux1 <= {f_ex[CW-1], f_ex} - {f_sx[CW-1], f_sx};
      uy1 <= {f_ey[CW-1], f_ey} - {f_sy[CW-1], f_sy};
      vx1 <= {s_ex[CW-1], s_ex} - {s_sx[CW-1], s_sx};
      vy1 <= {s_ey[CW-1], s_ey} - {s_sy[CW-1], s_sy};
      wx1 <= {f_sx[CW-1], f_sx} - {s_sx[CW-1], s_sx};
      wy1 <= {f_sy[CW-1], f_sy} - {s_sy[CW-1], s_sy};
      sx1 <= f_sx;
      sy1 <= f_sy;
    end
  end

  // stage 2: six products
  logic                 vld2;
  logic signed [MW-1:0] ma2, mb2, mc2, md2, me2, mf2;
  logic signed [DW-1:0] ux2, uy2;
  logic signed [CW-1:0] sx2, sy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma2 <= ux1 * vy1;
      mb2 <= uy1 * vx1;
      mc2 <= vx1 * wy1;
      md2 <= vy1 * wx1;
      me2 <= ux1 * wy1;
      mf2 <= uy1 * wx1;
      ux2 <= ux1;
      uy2 <= uy1;
      sx2 <= sx1;
      sy2 <= sy1;
    end
  end

  // stage 3: cross products, fold sign of D, range test
  logic signed [PW-1:0] d_w, p_w, q_w, d_n, p_n, q_n;
  logic                 hit_w;

  always_comb begin
    d_w   = {ma2[MW-1], ma2} - {mb2[MW-1], mb2};
    p_w   = {mc2[MW-1], mc2} - {md2[MW-1], md2};
    q_w   = {me2[MW-1], me2} - {mf2[MW-1], mf2};
    d_n   = d_w[PW-1] ? -d_w : d_w;
    p_n   = d_w[PW-1] ? -p_w : p_w;
    q_n   = d_w[PW-1] ? -q_w : q_w;
    hit_w = (d_w != '0) && !p_n[PW-1] && !q_n[PW-1] && (p_n <= d_n) && (q_n <= d_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit3 <= hit_w;
      d3   <= d_n;
      p3   <= p_n;
      ux3  <= ux2;
      uy3  <= uy2;
      sx3  <= sx2;
      sy3  <= sy2;
    end
  end
endmodule

### hw/rtl/sgi_div_step.sv
// ---------------------------------------------------------------------------
// Segment intersection divider step
// One restoring quotient bit for both axes, registered.
// ---------------------------------------------------------------------------
module sgi_div_step #(
  parameter int unsigned RW  = 54,
  parameter int unsigned QW  = 17,
  parameter int unsigned BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] m,
  input  logic [RW-1:0] rx,
  input  logic [RW-1:0] ry,
  input  logic [QW-1:0] qx,
  input  logic [QW-1:0] qy,
  output logic [RW-1:0] m_q,
  output logic [RW-1:0] rx_q,
  output logic [RW-1:0] ry_q,
  output logic [QW-1:0] qx_q,
  output logic [QW-1:0] qy_q
);
  logic [RW-1:0] ms;
  logic          gx, gy;
  logic [QW-1:0] qx_next, qy_next;

  always_comb begin
    ms      = m << BIT;
    gx      = rx >= ms;
    gy      = ry >= ms;
    qx_next = qx;
    qy_next = qy;
    qx_next[BIT] = gx;
    qy_next[BIT] = gy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_q  <= m;
      rx_q <= gx ? rx - ms : rx;
      ry_q <= gy ? ry - ms : ry;
      qx_q <= qx_next;
      qy_q <= qy_next;
    end
  end
endmodule

### hw/rtl/segment_segment_intersection.sv
// Path: stages 1..3, stage 4, divider setup, a step per quotient bit, output register.
// Throughput: one transfer per cycle when not stalled; holds up to COORD_WIDTH + 7 items.
// The whole pipeline advances together whenever the output register is empty or taken,
// so in_stall follows out_stall while a result waits.
// Reset (rst, synchronous, active high) clears every stage valid bit; payload is not reset.
// ---------------------------------------------------------------------------
// Segment intersection
// Tests two 2D fixed-point segments for intersection and returns the crossing
// point rounded to nearest, through a fully pipelined datapath.
// ---------------------------------------------------------------------------
module segment_segment_intersection #(
  parameter int unsigned COORD_WIDTH = sgi_pkg::COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] first_start_x,
  input  logic signed [COORD_WIDTH-1:0] first_start_y,
  input  logic signed [COORD_WIDTH-1:0] first_end_x,
  input  logic signed [COORD_WIDTH-1:0] first_end_y,
  input  logic signed [COORD_WIDTH-1:0] second_start_x,
  input  logic signed [COORD_WIDTH-1:0] second_start_y,
  input  logic signed [COORD_WIDTH-1:0] second_end_x,
  input  logic signed [COORD_WIDTH-1:0] second_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] hit_x,
  output logic signed [COORD_WIDTH-1:0] hit_y
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;          // direction vectors
  localparam int unsigned PW = 2 * DW + 1;      // cross products
  localparam int unsigned NW = DW + PW;         // u * p
  localparam int unsigned RW = NW + 2;          // dividend 2|u*p| + D
  localparam int unsigned QW = DW;              // quotient never exceeds |u|

  // global advance: move when the output slot is free or being taken
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stages 1..3: differences, products, cross products and hit test
  logic                 vld3, hit3;
  logic signed [PW-1:0] d3, p3;
  logic signed [DW-1:0] ux3, uy3;
  logic signed [CW-1:0] sx3, sy3;

  sgi_front #(.COORD_WIDTH(CW)) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (in_valid),
    .f_sx   (first_start_x),
    .f_sy   (first_start_y),
    .f_ex   (first_end_x),
    .f_ey   (first_end_y),
    .s_sx   (second_start_x),
    .s_sy   (second_start_y),
    .s_ex   (second_end_x),
    .s_ey   (second_end_y),
    .vld3   (vld3),
    .hit3   (hit3),
    .d3     (d3),
    .p3     (p3),
    .ux3    (ux3),
    .uy3    (uy3),
    .sx3    (sx3),
    .sy3    (sy3)
  );

  // stage 4: numerators u*p (p is never negative after the fold when the segments hit)
  logic                 vld4, hit4;
  logic signed [NW-1:0] nx4, ny4;
  logic signed [PW-1:0] d4;
  logic signed [CW-1:0] sx4, sy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (en) begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx4  <= ux3 * p3;
      ny4  <= uy3 * p3;
      d4   <= d3;
      hit4 <= hit3;
      sx4  <= sx3;
      sy4  <= sy3;
    end
  end

  // stage 5: round-to-nearest setup, q = (2|n| + D) / (2D), tie away from zero
  logic [NW-1:0] magx, magy;
  logic [RW-1:0] n2x, n2y, m2;

  always_comb begin
    magx = nx4[NW-1] ? NW'(-nx4) : NW'(nx4);
    magy = ny4[NW-1] ? NW'(-ny4) : NW'(ny4);
    n2x  = {1'b0, magx, 1'b0} + RW'(d4[PW-2:0]);
    n2y  = {1'b0, magy, 1'b0} + RW'(d4[PW-2:0]);
    m2   = RW'({d4[PW-2:0], 1'b0});
  end

  // divider pipeline, entry 0 is the setup register, one quotient bit per stage
  logic                 vld_p  [0:QW];
  logic                 hit_p  [0:QW];
  logic                 negx_p [0:QW];
  logic                 negy_p [0:QW];
  logic [CW-1:0]        sx_p   [0:QW];
  logic [CW-1:0]        sy_p   [0:QW];
  logic [RW-1:0]        m_p    [0:QW];
  logic [RW-1:0]        rx_p   [0:QW];
  logic [RW-1:0]        ry_p   [0:QW];
  logic [QW-1:0]        qx_p   [0:QW];
  logic [QW-1:0]        qy_p   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p[0] <= 1'b0;
    end else if (en) begin
      vld_p[0] <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_p[0]  <= hit4;
      negx_p[0] <= nx4[NW-1];
      negy_p[0] <= ny4[NW-1];
      sx_p[0]   <= sx4;
      sy_p[0]   <= sy4;
      m_p[0]    <= m2;
      rx_p[0]   <= n2x;
      ry_p[0]   <= n2y;
      qx_p[0]   <= '0;
      qy_p[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    sgi_div_step #(.RW(RW), .QW(QW), .BIT(QW - 1 - k)) u_step (
      .clk  (clk),
      .en   (en),
      .m    (m_p[k]),
      .rx   (rx_p[k]),
      .ry   (ry_p[k]),
      .qx   (qx_p[k]),
      .qy   (qy_p[k]),
      .m_q  (m_p[k+1]),
      .rx_q (rx_p[k+1]),
      .ry_q (ry_p[k+1]),
      .qx_q (qx_p[k+1]),
      .qy_q (qy_p[k+1])
    );

    // sideband travels with the divider stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_p[k+1] <= 1'b0;
      end else if (en) begin
        vld_p[k+1] <= vld_p[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hit_p[k+1]  <= hit_p[k];
        negx_p[k+1] <= negx_p[k];
        negy_p[k+1] <= negy_p[k];
        sx_p[k+1]   <= sx_p[k];
        sy_p[k+1]   <= sy_p[k];
      end
    end
  end

  // output stage: apply sign, add start point; the point lies on the first segment
  logic signed [DW-1:0] offx, offy, sumx, sumy;

  always_comb begin
    offx = negx_p[QW] ? -$signed(qx_p[QW]) : $signed(qx_p[QW]);
    offy = negy_p[QW] ? -$signed(qy_p[QW]) : $signed(qy_p[QW]);
    sumx = $signed({sx_p[QW][CW-1], sx_p[QW]}) + offx;
    sumy = $signed({sy_p[QW][CW-1], sy_p[QW]}) + offy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_p[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit   <= hit_p[QW];
      hit_x <= hit_p[QW] ? sumx[CW-1:0] : '0;
      hit_y <= hit_p[QW] ? sumy[CW-1:0] : '0;
    end
  end
endmodule

### hw/rtl/sgi_checker.sv
// ---------------------------------------------------------------------------
// Segment intersection checker
// Port-level checks of flow control and result encoding.
// ---------------------------------------------------------------------------
`include "segment_segment_intersection_macros.svh"

module sgi_checker #(
  parameter int unsigned COORD_WIDTH = sgi_pkg::COORD_WIDTH
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   hit,
  input logic [COORD_WIDTH-1:0] hit_x,
  input logic [COORD_WIDTH-1:0] hit_y
);
  `SGI_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "output valid after reset")
  `SGI_ASSERT(a_stall_link, clk, rst, in_stall == (out_valid && out_stall), "input stall mismatch")
  `SGI_ASSERT(a_miss_zero, clk, rst, (out_valid && !hit) |-> (hit_x == '0 && hit_y == '0), "miss with nonzero point")
  `SGI_ASSERT(a_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(hit) && $stable(hit_x) && $stable(hit_y)), "stalled result changed")
endmodule

bind segment_segment_intersection sgi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sgi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .hit_x     (hit_x),
  .hit_y     (hit_y)
);
